// ----- rtl/fcd_pkg.sv -----
`timescale 1ns / 1ps

package fcd_pkg;

    // Result kinds
    typedef enum logic [3:0] {
        KIND_VALVE     = 4'd0,
        KIND_PUMP      = 4'd1,
        KIND_PRESSURE  = 4'd2,
        KIND_UPTIME    = 4'd3,
        KIND_ERROR     = 4'd4,
        KIND_BAD_COUNT = 4'd5,
        KIND_BAD_SIZE  = 4'd6,
        KIND_UNKNOWN   = 4'd7,
        KIND_SHORT     = 4'd8
    } t_kind;

    // Configuration register indexes
    typedef enum logic [2:0] {
        CFG_START    = 3'd0,
        CFG_STOP     = 3'd1,
        CFG_ESCAPE   = 3'd2,
        CFG_VALVE    = 3'd3,
        CFG_PUMP     = 3'd4,
        CFG_PRESSURE = 3'd5,
        CFG_UPTIME   = 3'd6,
        CFG_ERROR    = 3'd7
    } t_cfg_index;

    localparam int unsigned KEEP_PARAMS  = 3;
    localparam int unsigned UPTIME_BYTES = 4;
    localparam logic [3:0]  COUNT_MAX    = 4'd15;

    // Body length states (saturates at two)
    localparam logic [1:0] BODY_EMPTY = 2'd0;
    localparam logic [1:0] BODY_CMD   = 2'd1;
    localparam logic [1:0] BODY_PARAM = 2'd2;

    // One decoded request
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  command_code;
        logic [7:0]  unit_number;
        logic        on_state;
        logic [7:0]  setpoint;
        logic [7:0]  measured;
        logic [31:0] uptime;
        logic [3:0]  param_count;
    } t_result;

endpackage

// ----- rtl/framed_command_decoder_core.sv -----
`timescale 1ns / 1ps

// Framed command decoder.
// Input channel: one received serial byte per request on i_rx_byte, taken
// when i_in_valid is high and o_in_stall is low. Bytes are dropped until the
// start code; inside a frame the escape code makes the next byte literal and
// an unescaped stop code closes the frame.
// Output channel: one decoded request per closed frame (kind, command and
// fields), taken when o_out_valid is high and i_out_stall is low.
// Throughput: one byte per cycle while o_in_stall is low. Each byte updates the
// frame state in the cycle it is taken; the result of a stop code is registered
// into the output register, or into the skid stage while that register waits.
// Stalls: the output register has a one-entry skid stage behind it, so the
// block keeps taking bytes while a result waits. Only when both are full does
// o_in_stall go high, and it is driven from a register.
// Reset (i_rst_n low, synchronous): frame state cleared, waiting for a start
// code, output empty, codes back to 240/241/242 and commands 1,2,3,5,6.
// Configuration: i_cfg_we writes i_cfg_data to register i_cfg_index; write
// only while the block is idle.
module framed_command_decoder_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // configuration
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [7:0]  i_cfg_data,
    // byte input
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic [7:0]  i_rx_byte,
    // result output
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [3:0]  o_kind,
    output logic [7:0]  o_command_code,
    output logic [7:0]  o_unit_number,
    output logic        o_on_state,
    output logic [7:0]  o_setpoint,
    output logic [7:0]  o_measured,
    output logic [31:0] o_uptime,
    output logic [3:0]  o_param_count
);

    // Configuration registers
    logic [7:0] r_start_code, r_stop_code, r_escape_code;
    logic [7:0] r_valve_cmd, r_pump_cmd, r_pressure_cmd, r_uptime_cmd, r_error_cmd;

    // Frame state
    logic        r_in_frame,   n_in_frame;
    logic        r_esc_pend,   n_esc_pend;
    logic [1:0]  r_body_len,   n_body_len;
    logic [7:0]  r_cmd_byte,   n_cmd_byte;
    logic        r_expect_len, n_expect_len;
    logic [7:0]  r_bytes_left, n_bytes_left;
    logic [3:0]  r_params,     n_params;
    logic [7:0]  r_first [fcd_pkg::KEEP_PARAMS];
    logic [7:0]  n_first [fcd_pkg::KEEP_PARAMS];
    logic [7:0]  r_plen  [fcd_pkg::KEEP_PARAMS];
    logic [7:0]  n_plen  [fcd_pkg::KEEP_PARAMS];
    logic [31:0] r_uptime,     n_uptime;

    // Output register and skid stage
    logic            r_out_valid, n_out_valid;
    logic            r_skid_valid, n_skid_valid;
    fcd_pkg::t_result r_out, n_out;
    fcd_pkg::t_result r_skid, n_skid;

    logic            w_accept;
    logic            w_res_valid;
    fcd_pkg::t_result w_res;

    assign o_in_stall = r_skid_valid;
    assign w_accept   = i_in_valid && !r_skid_valid;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start_code   <= 8'd240;
            r_stop_code    <= 8'd241;
            r_escape_code  <= 8'd242;
            r_valve_cmd    <= 8'd1;
            r_pump_cmd     <= 8'd2;
            r_pressure_cmd <= 8'd3;
            r_uptime_cmd   <= 8'd5;
            r_error_cmd    <= 8'd6;
        end else if (i_cfg_we) begin
            unique case (fcd_pkg::t_cfg_index'(i_cfg_index))
                fcd_pkg::CFG_START:    r_start_code   <= i_cfg_data;
                fcd_pkg::CFG_STOP:     r_stop_code    <= i_cfg_data;
                fcd_pkg::CFG_ESCAPE:   r_escape_code  <= i_cfg_data;
                fcd_pkg::CFG_VALVE:    r_valve_cmd    <= i_cfg_data;
                fcd_pkg::CFG_PUMP:     r_pump_cmd     <= i_cfg_data;
                fcd_pkg::CFG_PRESSURE: r_pressure_cmd <= i_cfg_data;
                fcd_pkg::CFG_UPTIME:   r_uptime_cmd   <= i_cfg_data;
                fcd_pkg::CFG_ERROR:    r_error_cmd    <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Result of the frame closing now (uses the state before the stop code)
    always_comb begin
        logic cmd_valve, cmd_pump, ones2, ones3;
        cmd_valve = (r_cmd_byte == r_valve_cmd);
        cmd_pump  = (r_cmd_byte == r_pump_cmd);
        ones2     = (r_plen[0] == 8'd1) && (r_plen[1] == 8'd1);
        ones3     = ones2 && (r_plen[2] == 8'd1);

        w_res              = '0;
        w_res.kind         = fcd_pkg::KIND_UNKNOWN;
        w_res.command_code = r_cmd_byte;
        w_res.param_count  = r_params;
        priority if (r_body_len != fcd_pkg::BODY_PARAM) begin
            w_res.kind = fcd_pkg::KIND_SHORT;
        end else if (cmd_valve || cmd_pump) begin
            if (r_params != 4'd2) begin
                w_res.kind = fcd_pkg::KIND_BAD_COUNT;
            end else if (!ones2) begin
                w_res.kind = fcd_pkg::KIND_BAD_SIZE;
            end else begin
                w_res.kind        = cmd_valve ? fcd_pkg::KIND_VALVE : fcd_pkg::KIND_PUMP;
                w_res.unit_number = r_first[0];
                w_res.on_state    = (r_first[1] != 8'd0);
            end
        end else if (r_cmd_byte == r_pressure_cmd) begin
            if (r_params != 4'd3) begin
                w_res.kind = fcd_pkg::KIND_BAD_COUNT;
            end else if (!ones3) begin
                w_res.kind = fcd_pkg::KIND_BAD_SIZE;
            end else begin
                w_res.kind        = fcd_pkg::KIND_PRESSURE;
                w_res.unit_number = r_first[0];
                w_res.setpoint    = r_first[1];
                w_res.measured    = r_first[2];
            end
        end else if (r_cmd_byte == r_uptime_cmd) begin
            if (r_params != 4'd1) begin
                w_res.kind = fcd_pkg::KIND_BAD_COUNT;
            end else if (r_plen[0] != 8'(fcd_pkg::UPTIME_BYTES)) begin
                w_res.kind = fcd_pkg::KIND_BAD_SIZE;
            end else begin
                w_res.kind   = fcd_pkg::KIND_UPTIME;
                w_res.uptime = r_uptime;
            end
        end else if (r_cmd_byte == r_error_cmd) begin
            w_res.kind = fcd_pkg::KIND_ERROR;
        end else begin
            w_res.kind = fcd_pkg::KIND_UNKNOWN;
        end
    end

    // Frame state update for one accepted byte
    always_comb begin
        logic       take, stop_hit;
        logic [7:0] b;
        logic [1:0] idx;
        logic       keep;
        logic [7:0] cur_len, pos, left;
        b        = i_rx_byte;
        take     = 1'b0;
        stop_hit = 1'b0;
        idx      = r_params[1:0];
        keep     = (r_params < 4'(fcd_pkg::KEEP_PARAMS));
        cur_len  = (idx == 2'd0) ? r_plen[0] : ((idx == 2'd1) ? r_plen[1] : r_plen[2]);
        pos      = cur_len - r_bytes_left;
        left     = r_bytes_left - 8'd1;

        n_in_frame   = r_in_frame;
        n_esc_pend   = r_esc_pend;
        n_body_len   = r_body_len;
        n_cmd_byte   = r_cmd_byte;
        n_expect_len = r_expect_len;
        n_bytes_left = r_bytes_left;
        n_params     = r_params;
        n_first      = r_first;
        n_plen       = r_plen;
        n_uptime     = r_uptime;

        // Framing: start, escape, stop
        if (w_accept) begin
            priority if (!r_in_frame) begin
                if (b == r_start_code) begin
                    n_in_frame = 1'b1;
                end
            end else if (r_esc_pend) begin
                n_esc_pend = 1'b0;
                take       = 1'b1;
            end else if (b == r_escape_code) begin
                n_esc_pend = 1'b1;
            end else if (b == r_stop_code) begin
                stop_hit   = 1'b1;
            end else begin
                take       = 1'b1;
            end
        end

        // Body: command byte, then length-prefixed parameters
        if (take) begin
            if (r_body_len == fcd_pkg::BODY_EMPTY) begin
                n_cmd_byte   = b;
                n_body_len   = fcd_pkg::BODY_CMD;
                n_expect_len = 1'b1;
            end else begin
                n_body_len = fcd_pkg::BODY_PARAM;
                if (r_expect_len) begin
                    n_bytes_left = b;
                    n_expect_len = 1'b0;
                    if (keep) begin
                        n_plen[idx] = b;
                    end
                    if (b == 8'd0) begin
                        n_expect_len = 1'b1;
                        if (r_params != fcd_pkg::COUNT_MAX) begin
                            n_params = r_params + 4'd1;
                        end
                    end
                end else begin
                    if (keep) begin
                        if (pos == 8'd0) begin
                            n_first[idx] = b;
                        end
                        if (idx == 2'd0 && pos < 8'(fcd_pkg::UPTIME_BYTES)) begin
                            n_uptime = r_uptime | ({24'd0, b} << {pos[1:0], 3'b000});
                        end
                    end
                    n_bytes_left = left;
                    if (left == 8'd0) begin
                        n_expect_len = 1'b1;
                        if (r_params != fcd_pkg::COUNT_MAX) begin
                            n_params = r_params + 4'd1;
                        end
                    end
                end
            end
        end

        // Start code or stop code: fresh message state
        if (stop_hit || (w_accept && !r_in_frame && b == r_start_code)) begin
            n_in_frame   = !stop_hit;
            n_esc_pend   = 1'b0;
            n_body_len   = fcd_pkg::BODY_EMPTY;
            n_cmd_byte   = 8'd0;
            n_expect_len = 1'b1;
            n_bytes_left = 8'd0;
            n_params     = 4'd0;
            n_uptime     = 32'd0;
            for (int i = 0; i < int'(fcd_pkg::KEEP_PARAMS); i++) begin
                n_first[i] = 8'd0;
                n_plen[i]  = 8'd0;
            end
        end

        w_res_valid = stop_hit;
    end

    // Output register with skid stage
    always_comb begin
        logic out_take;
        out_take     = r_out_valid && !i_out_stall;
        n_out_valid  = r_out_valid;
        n_out        = r_out;
        n_skid_valid = r_skid_valid;
        n_skid       = r_skid;
        if (r_skid_valid) begin
            if (out_take) begin
                n_out        = r_skid;
                n_skid_valid = 1'b0;
            end
        end else if (!r_out_valid || out_take) begin
            n_out_valid = w_res_valid;
            n_out       = w_res;
        end else if (w_res_valid) begin
            n_skid_valid = 1'b1;
            n_skid       = w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_frame   <= 1'b0;
            r_esc_pend   <= 1'b0;
            r_body_len   <= fcd_pkg::BODY_EMPTY;
            r_cmd_byte   <= 8'd0;
            r_expect_len <= 1'b1;
            r_bytes_left <= 8'd0;
            r_params     <= 4'd0;
            r_uptime     <= 32'd0;
            for (int i = 0; i < int'(fcd_pkg::KEEP_PARAMS); i++) begin
                r_first[i] <= 8'd0;
                r_plen[i]  <= 8'd0;
            end
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_in_frame   <= n_in_frame;
            r_esc_pend   <= n_esc_pend;
            r_body_len   <= n_body_len;
            r_cmd_byte   <= n_cmd_byte;
            r_expect_len <= n_expect_len;
            r_bytes_left <= n_bytes_left;
            r_params     <= n_params;
            r_uptime     <= n_uptime;
            r_first      <= n_first;
            r_plen       <= n_plen;
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    // Result payload, no reset
    always_ff @(posedge i_clk) begin
        r_out  <= n_out;
        r_skid <= n_skid;
    end

    assign o_out_valid    = r_out_valid;
    assign o_kind         = r_out.kind;
    assign o_command_code = r_out.command_code;
    assign o_unit_number  = r_out.unit_number;
    assign o_on_state     = r_out.on_state;
    assign o_setpoint     = r_out.setpoint;
    assign o_measured     = r_out.measured;
    assign o_uptime       = r_out.uptime;
    assign o_param_count  = r_out.param_count;

    // Skid stage only fills behind a full output register
    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid stage full while output register empty");

    // A result arriving at a stalled output lands in the skid stage
    a_skid_load: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_out_stall && !r_skid_valid && w_res_valid) |=> r_skid_valid)
        else $error("result lost at stalled output");

    // Outside a frame the message state is clean
    a_idle_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_in_frame |-> (!r_esc_pend && r_body_len == fcd_pkg::BODY_EMPTY
                         && r_params == 4'd0))
        else $error("message state not cleared outside a frame");

    // Body length saturates at two
    a_body_len_sat: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_body_len != 2'd3)
        else $error("body length out of range");

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 1ps

module tb;

    localparam int unsigned CYCLE_LIMIT = 200000;
    localparam logic [63:0] DEFAULT_CODES =
        {8'hF0, 8'hF1, 8'hF2, 8'h01, 8'h02, 8'h03, 8'h05, 8'h06};

    // idle patterns
    localparam int GAP_NONE = 0;
    localparam int GAP_SEND = 1;
    localparam int GAP_RECV = 2;
    localparam int GAP_BOTH = 3;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [7:0]  i_cfg_data;
    logic        i_in_valid;
    logic        o_in_stall;
    logic [7:0]  i_rx_byte;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [3:0]  o_kind;
    logic [7:0]  o_command_code;
    logic [7:0]  o_unit_number;
    logic        o_on_state;
    logic [7:0]  o_setpoint;
    logic [7:0]  o_measured;
    logic [31:0] o_uptime;
    logic [3:0]  o_param_count;

    framed_command_decoder_core dut (.*);

    // directed frames, optionally preceded by a code setting
    typedef struct {
        bit               set_cfg;
        logic [63:0]      cfg;
        int               len;
        logic [159:0]     seq;
        bit               typed;
        fcd_pkg::t_result want;
    } t_dir_row;

    t_dir_row dir_rows[$];

    // decoder model: codes and frame state
    logic [7:0]  start_c, stop_c, esc_c, valve_c, pump_c, press_c, up_c, error_c;
    logic        in_frm, esc_pend, want_len;
    logic [1:0]  body_len;
    logic [7:0]  cmd_b, left;
    logic [3:0]  n_params;
    logic [7:0]  p_first[fcd_pkg::KEEP_PARAMS];
    logic [7:0]  p_len[fcd_pkg::KEEP_PARAMS];
    logic [31:0] up_acc;

    fcd_pkg::t_result pending_reports[$];
    bit               typed_armed;
    fcd_pkg::t_result typed_value;

    int          gap_mode;
    int unsigned cycle_count;
    int          errors;
    int          reports_seen;
    int          bytes_taken;
    int          frame_bytes;
    int          settings_applied;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic fcd_pkg::t_result rep(fcd_pkg::t_kind k, logic [7:0] cmd,
                                             logic [7:0] unit, logic on,
                                             logic [7:0] sp, logic [7:0] ms,
                                             logic [31:0] up, logic [3:0] cnt);
        fcd_pkg::t_result r;
        r.kind = k;
        r.command_code = cmd;
        r.unit_number = unit;
        r.on_state = on;
        r.setpoint = sp;
        r.measured = ms;
        r.uptime = up;
        r.param_count = cnt;
        return r;
    endfunction

    function void add_row(bit set_cfg, logic [63:0] cfg, int len, logic [159:0] seq,
                          bit typed, fcd_pkg::t_result want);
        t_dir_row r;
        r.set_cfg = set_cfg;
        r.cfg = cfg;
        r.len = len;
        r.seq = seq;
        r.typed = typed;
        r.want = want;
        dir_rows.insert(dir_rows.size(), r);
    endfunction

    function void clear_frame();
        esc_pend = 1'b0;
        body_len = fcd_pkg::BODY_EMPTY;
        cmd_b = 8'h00;
        want_len = 1'b1;
        left = 8'h00;
        n_params = 4'd0;
        up_acc = 32'h0;
        for (int i = 0; i < int'(fcd_pkg::KEEP_PARAMS); i++) begin
            p_first[i] = 8'h00;
            p_len[i] = 8'h00;
        end
    endfunction

    function void reset_model();
        {start_c, stop_c, esc_c, valve_c, pump_c, press_c, up_c, error_c} = DEFAULT_CODES;
        in_frm = 1'b0;
        clear_frame();
    endfunction

    function void write_model_reg(logic [2:0] idx, logic [7:0] v);
        case (fcd_pkg::t_cfg_index'(idx))
            fcd_pkg::CFG_START:    start_c = v;
            fcd_pkg::CFG_STOP:     stop_c = v;
            fcd_pkg::CFG_ESCAPE:   esc_c = v;
            fcd_pkg::CFG_VALVE:    valve_c = v;
            fcd_pkg::CFG_PUMP:     pump_c = v;
            fcd_pkg::CFG_PRESSURE: press_c = v;
            fcd_pkg::CFG_UPTIME:   up_c = v;
            fcd_pkg::CFG_ERROR:    error_c = v;
            default:               ;
        endcase
    endfunction

    function void close_param();
        if (n_params != fcd_pkg::COUNT_MAX)
            n_params++;
        want_len = 1'b1;
    endfunction

    // command byte, then length byte and data bytes per parameter
    function void take_body_byte(logic [7:0] b);
        logic [3:0] idx;
        logic [7:0] pos;
        idx = n_params;
        if (body_len == fcd_pkg::BODY_EMPTY) begin
            cmd_b = b;
            body_len = fcd_pkg::BODY_CMD;
            want_len = 1'b1;
            return;
        end
        body_len = fcd_pkg::BODY_PARAM;
        if (want_len) begin
            left = b;
            want_len = 1'b0;
            if (idx < 4'(fcd_pkg::KEEP_PARAMS))
                p_len[idx[1:0]] = b;
            if (b == 8'h00)
                close_param();
            return;
        end
        if (idx < 4'(fcd_pkg::KEEP_PARAMS)) begin
            pos = p_len[idx[1:0]] - left;
            if (pos == 8'h00)
                p_first[idx[1:0]] = b;
            if (idx == 4'd0 && pos < 8'(fcd_pkg::UPTIME_BYTES))
                up_acc = up_acc | (32'(b) << (8 * pos));
        end
        left--;
        if (left == 8'h00)
            close_param();
    endfunction

    function automatic bit all_single(int n);
        for (int i = 0; i < n && i < int'(fcd_pkg::KEEP_PARAMS); i++)
            if (p_len[i] != 8'd1)
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic fcd_pkg::t_result build_report();
        fcd_pkg::t_result r;
        r = '0;
        r.command_code = cmd_b;
        r.param_count = n_params;
        if (body_len != fcd_pkg::BODY_PARAM) begin
            r.kind = fcd_pkg::KIND_SHORT;
        end else if (cmd_b == valve_c || cmd_b == pump_c) begin
            if (n_params != 4'd2) r.kind = fcd_pkg::KIND_BAD_COUNT;
            else if (!all_single(2)) r.kind = fcd_pkg::KIND_BAD_SIZE;
            else begin
                r.kind = (cmd_b == valve_c) ? fcd_pkg::KIND_VALVE : fcd_pkg::KIND_PUMP;
                r.unit_number = p_first[0];
                r.on_state = (p_first[1] != 8'h00);
            end
        end else if (cmd_b == press_c) begin
            if (n_params != 4'd3) r.kind = fcd_pkg::KIND_BAD_COUNT;
            else if (!all_single(3)) r.kind = fcd_pkg::KIND_BAD_SIZE;
            else begin
                r.kind = fcd_pkg::KIND_PRESSURE;
                r.unit_number = p_first[0];
                r.setpoint = p_first[1];
                r.measured = p_first[2];
            end
        end else if (cmd_b == up_c) begin
            if (n_params != 4'd1) r.kind = fcd_pkg::KIND_BAD_COUNT;
            else if (p_len[0] != 8'(fcd_pkg::UPTIME_BYTES)) r.kind = fcd_pkg::KIND_BAD_SIZE;
            else begin
                r.kind = fcd_pkg::KIND_UPTIME;
                r.uptime = up_acc;
            end
        end else if (cmd_b == error_c) begin
            r.kind = fcd_pkg::KIND_ERROR;
        end else begin
            r.kind = fcd_pkg::KIND_UNKNOWN;
        end
        return r;
    endfunction

    // one accepted serial byte through the frame decoder
    function void decode_byte(logic [7:0] b);
        if (!in_frm) begin
            if (b == start_c) begin
                in_frm = 1'b1;
                clear_frame();
            end
        end else if (esc_pend) begin
            esc_pend = 1'b0;
            take_body_byte(b);
        end else if (b == esc_c) begin
            esc_pend = 1'b1;
        end else if (b == stop_c) begin
            pending_reports.insert(pending_reports.size(),
                                   typed_armed ? typed_value : build_report());
            in_frm = 1'b0;
            clear_frame();
        end else begin
            take_body_byte(b);
        end
    endfunction

    function void check_field(string name, logic [31:0] want, logic [31:0] got);
        if (want !== got) begin
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name, want, got);
            errors++;
        end
    endfunction

    task automatic check_report();
        fcd_pkg::t_result want;
        if (pending_reports.size() == 0) begin
            $display("%0t ns: unexpected request, expected none, got kind %0d command %0h",
                     $time, o_kind, o_command_code);
            errors++;
        end else begin
            want = pending_reports.pop_front();
            check_field("kind", 32'(want.kind), 32'(o_kind));
            check_field("command_code", 32'(want.command_code), 32'(o_command_code));
            check_field("unit_number", 32'(want.unit_number), 32'(o_unit_number));
            check_field("on_state", 32'(want.on_state), 32'(o_on_state));
            check_field("setpoint", 32'(want.setpoint), 32'(o_setpoint));
            check_field("measured", 32'(want.measured), 32'(o_measured));
            check_field("uptime", want.uptime, o_uptime);
            check_field("param_count", 32'(want.param_count), 32'(o_param_count));
            reports_seen++;
        end
    endtask

    // sample both channels and the config port at the rising edge
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("Timed out after %0d cycles", cycle_count);
            $display("framed_command_decoder_core verification failed");
            $finish;
        end else if (!i_rst_n) begin
            reset_model();
        end else begin
            if (i_cfg_we)
                write_model_reg(i_cfg_index, i_cfg_data);
            if (i_in_valid && !o_in_stall) begin
                decode_byte(i_rx_byte);
                bytes_taken++;
            end
            if (o_out_valid && !i_out_stall)
                check_report();
        end
    end

    function automatic bit sender_gap();
        case (gap_mode)
            GAP_SEND: return $urandom_range(0, 99) < 45;
            GAP_BOTH: return $urandom_range(0, 99) < 18;
            default:  return 1'b0;
        endcase
    endfunction

    function automatic bit receiver_gap();
        case (gap_mode)
            GAP_RECV: return $urandom_range(0, 99) < 45;
            GAP_BOTH: return $urandom_range(0, 99) < 18;
            default:  return 1'b0;
        endcase
    endfunction

    always @(negedge i_clk) begin
        i_out_stall <= receiver_gap();
    end

    // present one byte and hold it until taken
    task automatic push_byte(input logic [7:0] b);
        while (sender_gap()) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_rx_byte <= b;
        @(posedge i_clk);
        while (o_in_stall)
            @(posedge i_clk);
        @(negedge i_clk);
    endtask

    task automatic set_reg(input fcd_pkg::t_cfg_index idx, input logic [7:0] v);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data <= v;
        @(negedge i_clk);
    endtask

    // drain outstanding requests, then rewrite every code register
    task automatic apply_setting(input logic [63:0] s);
        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(negedge i_clk);
        repeat (4) @(negedge i_clk);
        set_reg(fcd_pkg::CFG_START, s[63:56]);
        set_reg(fcd_pkg::CFG_STOP, s[55:48]);
        set_reg(fcd_pkg::CFG_ESCAPE, s[47:40]);
        set_reg(fcd_pkg::CFG_VALVE, s[39:32]);
        set_reg(fcd_pkg::CFG_PUMP, s[31:24]);
        set_reg(fcd_pkg::CFG_PRESSURE, s[23:16]);
        set_reg(fcd_pkg::CFG_UPTIME, s[15:8]);
        set_reg(fcd_pkg::CFG_ERROR, s[7:0]);
        i_cfg_we <= 1'b0;
        settings_applied++;
    endtask

    // body byte, stuffed where it would clash with stop or escape (always in tidy frames), and at random otherwise
    task automatic put_data(input logic [7:0] b, input bit tidy);
        bit clash;
        clash = (b == stop_c) || (b == esc_c);
        if ((clash && (tidy || $urandom_range(0, 3) != 0)) || $urandom_range(0, 15) == 0)
            push_byte(esc_c);
        push_byte(b);
        frame_bytes++;
    endtask

    // mostly well-formed frames; some with wrong counts, sizes or cut short
    task automatic make_frame();
        logic [7:0] body[$];
        logic [7:0] cmd;
        int nprm, plen, bad_idx, cut, lim, k;
        bit tidy;
        bad_idx = -1;
        cut = -1;
        if ($urandom_range(0, 19) == 0)
            repeat ($urandom_range(1, 3)) push_byte(8'($urandom));
        tidy = ($urandom_range(0, 7) != 0);
        case ($urandom_range(0, 5))
            0: begin cmd = valve_c; nprm = 2; plen = 1; end
            1: begin cmd = pump_c; nprm = 2; plen = 1; end
            2: begin cmd = press_c; nprm = 3; plen = 1; end
            3: begin cmd = up_c; nprm = 1; plen = fcd_pkg::UPTIME_BYTES; end
            4: begin
                cmd = error_c;
                nprm = $urandom_range(0, 3);
                plen = $urandom_range(0, 2);
            end
            default: begin
                cmd = 8'($urandom);
                nprm = $urandom_range(0, 4);
                plen = $urandom_range(0, 2);
            end
        endcase
        if (!tidy) begin
            case ($urandom_range(0, 3))
                0: begin nprm = $urandom_range(0, 17); plen = $urandom_range(0, 1); end
                1: nprm = $urandom_range(0, 4);
                2: bad_idx = $urandom_range(0, 3);
                default: cut = $urandom_range(0, 5);
            endcase
        end
        body.insert(body.size(), cmd);
        for (k = 0; k < nprm; k++) begin
            body.insert(body.size(), 8'((k == bad_idx) ? $urandom_range(0, 5) : plen));
            repeat (body[$])
                body.insert(body.size(),
                            ($urandom_range(0, 3) == 0) ? 8'h00 : 8'($urandom));
        end
        lim = (cut >= 0 && cut < body.size()) ? cut : body.size();
        push_byte(start_c);
        for (k = 0; k < lim; k++)
            put_data(body[k], tidy);
        push_byte(stop_c);
        frame_bytes += 2;
    endtask

    initial begin
        int target;
        i_rst_n = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = fcd_pkg::CFG_START;
        i_cfg_data = 8'h00;
        i_in_valid = 1'b0;
        i_rx_byte = 8'h00;
        i_out_stall = 1'b0;
        gap_mode = GAP_NONE;
        typed_armed = 1'b0;
        typed_value = '0;

        // escape before the start code is dropped; an empty frame reports short
        add_row(0, 64'h0, 3, {8'hF2, 8'hF0, 8'hF1}, 1,
                rep(fcd_pkg::KIND_SHORT, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd0));
        add_row(0, 64'h0, 3, {8'hF0, 8'h07, 8'hF1}, 1,
                rep(fcd_pkg::KIND_SHORT, 8'h07, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd0));
        add_row(0, 64'h0, 7, {8'hF0, 8'h01, 8'h01, 8'hFF, 8'h01, 8'h80, 8'hF1}, 1,
                rep(fcd_pkg::KIND_VALVE, 8'h01, 8'hFF, 1'b1, 8'h00, 8'h00, 32'h0, 4'd2));
        add_row(0, 64'h0, 7, {8'hF0, 8'h02, 8'h01, 8'h00, 8'h01, 8'h00, 8'hF1}, 1,
                rep(fcd_pkg::KIND_PUMP, 8'h02, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd2));
        add_row(0, 64'h0, 9,
                {8'hF0, 8'h03, 8'h01, 8'h12, 8'h01, 8'hFF, 8'h01, 8'h00, 8'hF1}, 0, '0);
        add_row(0, 64'h0, 8, {8'hF0, 8'h05, 8'h04, 32'hFFFF_FFFF, 8'hF1}, 1,
                rep(fcd_pkg::KIND_UPTIME, 8'h05, 8'h00, 1'b0, 8'h00, 8'h00,
                    32'hFFFF_FFFF, 4'd1));
        // error report with a parameter cut off by the stop code
        add_row(0, 64'h0, 5, {8'hF0, 8'h06, 8'h05, 8'hAA, 8'hF1}, 1,
                rep(fcd_pkg::KIND_ERROR, 8'h06, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd0));
        add_row(0, 64'h0, 5, {8'hF0, 8'h01, 8'h01, 8'h05, 8'hF1}, 1,
                rep(fcd_pkg::KIND_BAD_COUNT, 8'h01, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd1));
        add_row(0, 64'h0, 8, {8'hF0, 8'h02, 8'h02, 8'h05, 8'h06, 8'h01, 8'h00, 8'hF1}, 1,
                rep(fcd_pkg::KIND_BAD_SIZE, 8'h02, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd2));
        // zero-length parameter counts at once
        add_row(0, 64'h0, 4, {8'hF0, 8'hFF, 8'h00, 8'hF1}, 1,
                rep(fcd_pkg::KIND_UNKNOWN, 8'hFF, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd1));
        // stuffed stop, start and escape as parameter data
        add_row(0, 64'h0, 12, {8'hF0, 8'h03, 8'h01, 8'hF2, 8'hF1, 8'h01, 8'hF2, 8'hF0,
                               8'h01, 8'hF2, 8'hF2, 8'hF1}, 0, '0);
        // bare start code inside a frame is data
        add_row(0, 64'h0, 8, {8'hF0, 8'h05, 8'h04, 8'hF0, 8'hF0, 8'h00, 8'h01, 8'hF1}, 0, '0);
        // sixteen empty parameters, count saturates
        add_row(0, 64'h0, 19, {8'hF0, 8'h00, 128'h0, 8'hF1}, 1,
                rep(fcd_pkg::KIND_UNKNOWN, 8'h00, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd15));
        // parameters past the third are counted only
        add_row(0, 64'h0, 12, {8'hF0, 8'h06, 8'h01, 8'hAA, 8'h01, 8'hBB, 8'h01, 8'hCC,
                               8'h02, 8'hDD, 8'hEE, 8'hF1}, 0, '0);
        add_row(0, 64'h0, 6, {8'hF0, 8'h05, 8'h04, 8'h01, 8'h02, 8'hF1}, 1,
                rep(fcd_pkg::KIND_BAD_COUNT, 8'h05, 8'h00, 1'b0, 8'h00, 8'h00, 32'h0, 4'd0));
        // valve and pump share a command byte: valve wins
        add_row(1, {8'hF0, 8'hF1, 8'hF2, 8'h01, 8'h01, 8'h03, 8'h05, 8'h06}, 7,
                {8'hF0, 8'h01, 8'h01, 8'h07, 8'h01, 8'h01, 8'hF1}, 0, '0);
        // escape equal to stop: frame stays open
        add_row(1, {8'hF0, 8'hF1, 8'hF1, 8'h01, 8'h02, 8'h03, 8'h05, 8'h06}, 6,
                {8'hF0, 8'h06, 8'h00, 8'hF1, 8'hF1, 8'hF1}, 0, '0);
        add_row(1, DEFAULT_CODES, 2, {8'hF1, 8'hF1}, 0, '0);

        repeat (7) @(negedge i_clk);
        i_rst_n <= 1'b1;

        foreach (dir_rows[r]) begin
            if (dir_rows[r].set_cfg)
                apply_setting(dir_rows[r].cfg);
            typed_armed = dir_rows[r].typed;
            typed_value = dir_rows[r].want;
            for (int j = 0; j < dir_rows[r].len; j++)
                push_byte(dir_rows[r].seq[(dir_rows[r].len - 1 - j) * 8 +: 8]);
            typed_armed = 1'b0;
        end

        // random frames over a sequence of code settings and idle patterns
        frame_bytes = 0;
        target = 0;
        for (int ph = 0; ph < 8; ph++) begin
            case (ph)
                0: ;
                1: apply_setting({8'h00, 8'hFF, 8'h7F, 8'h00, 8'h00, 8'hFF, 8'hFF, 8'h80});
                2: apply_setting({8'hFF, 8'h5A, 8'h5A, 8'h10, 8'h11, 8'h12, 8'h13, 8'h00});
                3: apply_setting(DEFAULT_CODES);
                default: apply_setting({8'($urandom), 8'($urandom), 8'($urandom),
                                        8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 7)), 8'($urandom_range(0, 7)),
                                        8'($urandom_range(0, 7))});
            endcase
            gap_mode = ph % 4;
            target += (ph == 2) ? 40 : 200;
            while (frame_bytes < target)
                make_frame();
        end

        i_in_valid <= 1'b0;
        while (pending_reports.size() != 0)
            @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Checked %0d decoded requests from %0d accepted serial bytes",
                 reports_seen, bytes_taken);
        $display("Ran %0d code settings over four idle and back-pressure patterns",
                 settings_applied + 1);
        if (errors == 0) begin
            $display("framed_command_decoder_core verification clean");
        end else begin
            $display("%0d mismatches", errors);
            $display("framed_command_decoder_core verification failed");
        end
        $finish;
    end

endmodule
